// ----- hdl/mx86eu_pkg.sv -----
// Package for the mini x86 execute unit: beat types, opcode and operand-mode codes,
// register numbers and the flag helpers.
// Standalone; used by mini_x86_execute_unit_top (mx86eu_ram does not use it).
package mx86eu_pkg;

    localparam int NUM_REGS = 16;

    localparam logic [3:0] CMD_MOV   = 4'd0;
    localparam logic [3:0] CMD_PUSH  = 4'd1;
    localparam logic [3:0] CMD_POP   = 4'd2;
    localparam logic [3:0] CMD_LEAVE = 4'd3;
    localparam logic [3:0] CMD_CALL  = 4'd4;
    localparam logic [3:0] CMD_RET   = 4'd5;
    localparam logic [3:0] CMD_ADD   = 4'd6;
    localparam logic [3:0] CMD_SUB   = 4'd7;
    localparam logic [3:0] CMD_CMP   = 4'd8;
    localparam logic [3:0] CMD_JNE   = 4'd9;
    localparam logic [3:0] CMD_JMP   = 4'd10;

    localparam logic [3:0] MODE_EMPTY   = 4'd0;
    localparam logic [3:0] MODE_IMM     = 4'd1;
    localparam logic [3:0] MODE_REG     = 4'd2;
    localparam logic [3:0] MODE_D       = 4'd3;
    localparam logic [3:0] MODE_B       = 4'd4;
    localparam logic [3:0] MODE_DB      = 4'd5;
    localparam logic [3:0] MODE_BX      = 4'd6;
    localparam logic [3:0] MODE_DBX     = 4'd7;
    localparam logic [3:0] MODE_XS      = 4'd8;
    localparam logic [3:0] MODE_DXS     = 4'd9;
    localparam logic [3:0] MODE_BXS     = 4'd10;
    localparam logic [3:0] MODE_DBXS    = 4'd11;

    localparam logic [3:0] REG_RBP = 4'd6;
    localparam logic [3:0] REG_RSP = 4'd7;
    localparam logic [4:0] REG_NONE = 5'd16;

    localparam logic [2:0] CFG_PC_STEP = 3'd0;
    localparam logic [7:0] PC_STEP_RESET = 8'd64;
    localparam logic [63:0] WORD_BYTES = 64'd8;

    typedef struct packed {
        logic [3:0]  command;
        logic [3:0]  src_mode;
        logic [63:0] src_imm;
        logic [3:0]  src_base;
        logic [3:0]  src_index;
        logic [3:0]  src_scale;
        logic [3:0]  dst_mode;
        logic [63:0] dst_imm;
        logic [3:0]  dst_base;
        logic [3:0]  dst_index;
        logic [3:0]  dst_scale;
    } cmd_beat_t;

    typedef struct packed {
        logic        executed;
        logic [63:0] next_pc;
        logic        carry_flag;
        logic        zero_flag;
        logic        sign_flag;
        logic        overflow_flag;
        logic [4:0]  reg_written;
        logic [63:0] reg_value;
        logic        mem_written;
        logic [63:0] mem_address;
        logic [63:0] mem_value;
    } res_beat_t;

    function automatic logic is_mem(input logic [3:0] mode);
        return (mode >= MODE_D) && (mode <= MODE_DBXS);
    endfunction

    // Effective address; bv and xv are the base and index register values.
    function automatic logic [63:0] eff_addr(input logic [3:0] mode, input logic [63:0] imm,
                                             input logic [63:0] bv, input logic [63:0] xv,
                                             input logic [3:0] scale);
        logic [63:0] xs;
        logic [63:0] res;
        xs = xv * {60'd0, scale};
        case (mode)
            MODE_D:    res = imm;
            MODE_B:    res = bv;
            MODE_DB:   res = imm + bv;
            MODE_BX:   res = bv + xv;
            MODE_DBX:  res = imm + bv + xv;
            MODE_XS:   res = xs;
            MODE_DXS:  res = imm + xs;
            MODE_BXS:  res = bv + xs;
            MODE_DBXS: res = imm + bv + xs;
            default:   res = 64'd0;
        endcase
        return res;
    endfunction

    // Flags as {OF, SF, ZF, CF} for d - s.
    function automatic logic [3:0] sub_flags(input logic [63:0] d, input logic [63:0] s);
        logic [63:0] v;
        v = d - s;
        return {(s[63] != d[63]) && (v[63] == s[63]), v[63], v == 64'd0, d < s};
    endfunction

    function automatic logic [3:0] add_flags(input logic [63:0] d, input logic [63:0] s);
        logic [63:0] v;
        v = d + s;
        return {(s[63] == d[63]) && (v[63] != s[63]), v[63], v == 64'd0, v < s};
    endfunction

endpackage

// ----- hdl/mx86eu_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module mx86eu_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- hdl/mini_x86_execute_unit_top.sv -----
// Mini x86 execute unit: executes one decoded instruction per command beat.
// The command beat and its data memory read are registered; write-back then registers the
// result beat, held off while res_stall holds a result. cmd_stall is high until write-back.
// Reset: registers, program counter and flags clear at once; the data memory is then
// cleared one word per cycle, word 0 up to MEM_WORDS-1, during which cmd_stall is high.
// Depends on mx86eu_pkg and mx86eu_ram.
module mini_x86_execute_unit_top #(
    parameter int MEM_WORDS = 4096
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cmd_valid,
    output logic                  cmd_stall,
    input  mx86eu_pkg::cmd_beat_t cmd_beat,
    output logic                  res_valid,
    input  logic                  res_stall,
    output mx86eu_pkg::res_beat_t res_beat,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [2:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    localparam int AW = $clog2(MEM_WORDS);

    logic [63:0] regs_reg [mx86eu_pkg::NUM_REGS];
    logic [63:0] pc_reg;
    logic [3:0]  flags_reg;
    logic [7:0]  pc_step_reg;
    logic        clr_reg;
    logic [AW-1:0] clr_cnt_reg;
    logic        busy_reg;
    mx86eu_pkg::cmd_beat_t item_reg;
    logic [63:0] sa_reg;
    logic [63:0] da_reg;
    logic        res_valid_reg;
    mx86eu_pkg::res_beat_t res_reg;

    logic        accept;
    logic        fire;
    logic [63:0] sa_in;
    logic [63:0] da_in;
    logic [63:0] rd_addr;
    logic [63:0] rdata;
    logic [AW-1:0] ram_waddr;
    logic [63:0] ram_wdata;
    logic        ram_we;

    logic        ok;
    logic [63:0] new_pc;
    logic [3:0]  new_flags;
    logic        wa_en;
    logic [3:0]  wa_idx;
    logic [63:0] wa_val;
    logic        wb_en;
    logic [3:0]  wb_idx;
    logic [63:0] wb_val;
    logic        mw_en;
    logic [63:0] mw_addr;
    logic [63:0] mw_val;

    function automatic logic [AW-1:0] word_idx(input logic [63:0] a);
        logic [63:0] w;
        w = (a >> 3) % 64'(MEM_WORDS);
        return w[AW-1:0];
    endfunction

    function automatic logic [3:0] eff_scale(input logic [3:0] mode, input logic [3:0] s);
        return (mode == mx86eu_pkg::MODE_BX || mode == mx86eu_pkg::MODE_DBX) ? 4'd1 : s;
    endfunction

    assign accept    = cmd_valid && !cmd_stall;
    assign cmd_stall = busy_reg || clr_reg;
    assign fire      = busy_reg && !(res_valid_reg && res_stall);

    assign sa_in = mx86eu_pkg::eff_addr(cmd_beat.src_mode, cmd_beat.src_imm,
                                        regs_reg[cmd_beat.src_base], regs_reg[cmd_beat.src_index],
                                        eff_scale(cmd_beat.src_mode, cmd_beat.src_scale));
    assign da_in = mx86eu_pkg::eff_addr(cmd_beat.dst_mode, cmd_beat.dst_imm,
                                        regs_reg[cmd_beat.dst_base], regs_reg[cmd_beat.dst_index],
                                        eff_scale(cmd_beat.dst_mode, cmd_beat.dst_scale));

    always_comb
    begin
        case (cmd_beat.command)
            mx86eu_pkg::CMD_POP:   rd_addr = regs_reg[mx86eu_pkg::REG_RSP];
            mx86eu_pkg::CMD_RET:   rd_addr = regs_reg[mx86eu_pkg::REG_RSP];
            mx86eu_pkg::CMD_LEAVE: rd_addr = regs_reg[mx86eu_pkg::REG_RBP];
            mx86eu_pkg::CMD_CMP:   rd_addr = da_in;
            default:               rd_addr = sa_in;
        endcase
    end

    assign ram_we    = clr_reg || (fire && mw_en);
    assign ram_waddr = clr_reg ? clr_cnt_reg : word_idx(mw_addr);
    assign ram_wdata = clr_reg ? 64'd0 : mw_val;

    mx86eu_ram #(
        .WIDTH (64),
        .DEPTH (MEM_WORDS)
    ) u_dmem (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (accept),
        .raddr (word_idx(rd_addr)),
        .rdata (rdata)
    );

    always_comb
    begin
        logic [63:0] seq;
        logic [63:0] sv;
        logic [63:0] dv;
        logic [63:0] rsp;
        logic [63:0] target;
        logic [3:0]  sm;
        logic [3:0]  dm;
        sm = item_reg.src_mode;
        dm = item_reg.dst_mode;
        seq = pc_reg + {56'd0, pc_step_reg};
        sv = regs_reg[item_reg.src_base];
        dv = regs_reg[item_reg.dst_base];
        rsp = regs_reg[mx86eu_pkg::REG_RSP];
        if (sm == mx86eu_pkg::MODE_IMM)
        begin
            target = item_reg.src_imm;
        end
        else if (sm == mx86eu_pkg::MODE_REG)
        begin
            target = sv;
        end
        else
        begin
            target = sa_reg;
        end
        ok = 1'b1;
        new_pc = seq;
        new_flags = 4'd0;
        wa_en = 1'b0;
        wa_idx = mx86eu_pkg::REG_RSP;
        wa_val = 64'd0;
        wb_en = 1'b0;
        wb_idx = item_reg.dst_base;
        wb_val = 64'd0;
        mw_en = 1'b0;
        mw_addr = 64'd0;
        mw_val = 64'd0;
        case (item_reg.command)
            mx86eu_pkg::CMD_MOV:
            begin
                if (sm == mx86eu_pkg::MODE_REG && dm == mx86eu_pkg::MODE_REG)
                begin
                    wb_en = 1'b1;
                    wb_val = sv;
                end
                else if (sm == mx86eu_pkg::MODE_REG && mx86eu_pkg::is_mem(dm))
                begin
                    mw_en = 1'b1;
                    mw_addr = da_reg;
                    mw_val = sv;
                end
                else if (mx86eu_pkg::is_mem(sm) && dm == mx86eu_pkg::MODE_REG)
                begin
                    wb_en = 1'b1;
                    wb_val = rdata;
                end
                else if (sm == mx86eu_pkg::MODE_IMM && dm == mx86eu_pkg::MODE_REG)
                begin
                    wb_en = 1'b1;
                    wb_val = item_reg.src_imm;
                end
                else
                begin
                    ok = 1'b0;
                end
            end
            mx86eu_pkg::CMD_PUSH:
            begin
                if (sm == mx86eu_pkg::MODE_REG)
                begin
                    wa_en = 1'b1;
                    wa_val = rsp - mx86eu_pkg::WORD_BYTES;
                    mw_en = 1'b1;
                    mw_addr = rsp - mx86eu_pkg::WORD_BYTES;
                    mw_val = sv;
                end
                else
                begin
                    ok = 1'b0;
                end
            end
            mx86eu_pkg::CMD_POP:
            begin
                if (sm == mx86eu_pkg::MODE_REG)
                begin
                    wa_en = 1'b1;
                    wa_val = rsp + mx86eu_pkg::WORD_BYTES;
                    wb_en = 1'b1;
                    wb_idx = item_reg.src_base;
                    wb_val = rdata;
                end
                else
                begin
                    ok = 1'b0;
                end
            end
            mx86eu_pkg::CMD_LEAVE:
            begin
                wa_en = 1'b1;
                wa_val = regs_reg[mx86eu_pkg::REG_RBP] + mx86eu_pkg::WORD_BYTES;
                wb_en = 1'b1;
                wb_idx = mx86eu_pkg::REG_RBP;
                wb_val = rdata;
            end
            mx86eu_pkg::CMD_CALL:
            begin
                new_pc = target;
                wa_en = 1'b1;
                wa_val = rsp - mx86eu_pkg::WORD_BYTES;
                mw_en = 1'b1;
                mw_addr = rsp - mx86eu_pkg::WORD_BYTES;
                mw_val = seq;
            end
            mx86eu_pkg::CMD_RET:
            begin
                new_pc = rdata;
                wa_en = 1'b1;
                wa_val = rsp + mx86eu_pkg::WORD_BYTES;
            end
            mx86eu_pkg::CMD_ADD:
            begin
                if (sm == mx86eu_pkg::MODE_REG && dm == mx86eu_pkg::MODE_REG)
                begin
                    new_flags = mx86eu_pkg::add_flags(dv, sv);
                    wb_en = 1'b1;
                    wb_val = dv + sv;
                end
                else
                begin
                    ok = 1'b0;
                end
            end
            mx86eu_pkg::CMD_SUB:
            begin
                if (sm == mx86eu_pkg::MODE_IMM && dm == mx86eu_pkg::MODE_REG)
                begin
                    new_flags = mx86eu_pkg::sub_flags(dv, item_reg.src_imm);
                    wb_en = 1'b1;
                    wb_val = dv - item_reg.src_imm;
                end
                else
                begin
                    ok = 1'b0;
                end
            end
            mx86eu_pkg::CMD_CMP:
            begin
                if (sm == mx86eu_pkg::MODE_IMM && mx86eu_pkg::is_mem(dm))
                begin
                    new_flags = mx86eu_pkg::sub_flags(rdata, item_reg.src_imm);
                end
                else
                begin
                    ok = 1'b0;
                end
            end
            mx86eu_pkg::CMD_JNE:
            begin
                if (sm == mx86eu_pkg::MODE_D)
                begin
                    if (!flags_reg[1])
                    begin
                        new_pc = item_reg.src_imm;
                    end
                end
                else
                begin
                    ok = 1'b0;
                end
            end
            mx86eu_pkg::CMD_JMP:
            begin
                new_pc = target;
            end
            default:
            begin
                ok = 1'b0;
            end
        endcase
        if (!ok)
        begin
            wa_en = 1'b0;
            wb_en = 1'b0;
            mw_en = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < mx86eu_pkg::NUM_REGS; i++)
            begin
                regs_reg[i] <= 64'd0;
            end
            pc_reg        <= 64'd0;
            flags_reg     <= 4'd0;
            pc_step_reg   <= mx86eu_pkg::PC_STEP_RESET;
            clr_reg       <= 1'b1;
            clr_cnt_reg   <= '0;
            busy_reg      <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (psel && penable && pwrite && paddr[2] == mx86eu_pkg::CFG_PC_STEP[2])
            begin
                pc_step_reg <= pwdata[7:0];
            end
            if (clr_reg)
            begin
                clr_cnt_reg <= clr_cnt_reg + AW'(1);
                if (clr_cnt_reg == AW'(MEM_WORDS - 1))
                begin
                    clr_reg <= 1'b0;
                end
            end
            if (accept)
            begin
                busy_reg <= 1'b1;
            end
            else if (fire)
            begin
                busy_reg <= 1'b0;
            end
            if (fire)
            begin
                res_valid_reg <= 1'b1;
                if (ok)
                begin
                    pc_reg    <= new_pc;
                    flags_reg <= new_flags;
                end
                if (wa_en && !(wb_en && wb_idx == wa_idx))
                begin
                    regs_reg[wa_idx] <= wa_val;
                end
                if (wb_en)
                begin
                    regs_reg[wb_idx] <= wb_val;
                end
            end
            else if (!res_stall)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= cmd_beat;
            sa_reg   <= sa_in;
            da_reg   <= da_in;
        end
        if (fire)
        begin
            res_reg.executed      <= ok;
            res_reg.next_pc       <= ok ? new_pc : pc_reg;
            res_reg.carry_flag    <= ok ? new_flags[0] : flags_reg[0];
            res_reg.zero_flag     <= ok ? new_flags[1] : flags_reg[1];
            res_reg.sign_flag     <= ok ? new_flags[2] : flags_reg[2];
            res_reg.overflow_flag <= ok ? new_flags[3] : flags_reg[3];
            if (wb_en)
            begin
                res_reg.reg_written <= {1'b0, wb_idx};
                res_reg.reg_value   <= wb_val;
            end
            else if (wa_en)
            begin
                res_reg.reg_written <= {1'b0, wa_idx};
                res_reg.reg_value   <= wa_val;
            end
            else
            begin
                res_reg.reg_written <= mx86eu_pkg::REG_NONE;
                res_reg.reg_value   <= 64'd0;
            end
            res_reg.mem_written <= mw_en;
            res_reg.mem_address <= mw_addr;
            res_reg.mem_value   <= mw_val;
        end
    end

    assign res_valid = res_valid_reg;
    assign res_beat  = res_reg;
    assign pready    = 1'b1;
    assign prdata    = (paddr[2] == mx86eu_pkg::CFG_PC_STEP[2]) ? {24'd0, pc_step_reg} : 32'd0;

endmodule
